FILE: src/imu_complementary_filter_top_macros.svh
// Assertion helpers for the complementary filter
`ifndef IMU_COMPLEMENTARY_FILTER_TOP_MACROS_SVH
`define IMU_COMPLEMENTARY_FILTER_TOP_MACROS_SVH

// check that cond implies next-cycle consequence
`define ICF_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

// check that cond implies same-cycle consequence
`define ICF_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

`endif

FILE: src/icf_pkg.sv
package icf_pkg;
	localparam int CordicStepsDefault = 20;
	localparam int AngleFracDefault   = 16;
	localparam int CordicW            = 64;
	localparam int StepW              = 5;

	typedef enum logic [2:0] {
		REG_BLEND = 3'd0,
		REG_GAIN  = 3'd1,
		REG_MLOW  = 3'd2,
		REG_MHIGH = 3'd3
	} reg_idx_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture sample, integrate gyro, compute magnitude
		logic cor_init;  // start CORDIC on pitch (sel=0) or roll (sel=1)
		logic cor_step;  // one CORDIC iteration
		logic blend_mul; // register the two blend products
		logic blend_wr;  // write blended angle back
		logic sel;       // 0 pitch, 1 roll
		logic out_load;  // capture results into output register
	} icf_cmd_t;

	typedef struct packed {
		logic corr;      // correction applies to this sample
		logic cor_last;  // current CORDIC step is the last
	} icf_sts_t;

	// atan(2^-i) in degrees, Q32
	function automatic logic [63:0] atan_deg_q32(input int i);
		logic [63:0] rad;
		logic [63:0] term;
		int s;
		rad = 64'd0;
		if (i == 0) return 64'd45 << 32;
		for (int k = 0; k < 32; k++) begin
			s = i + 2 * i * k;
			if (s <= 62) begin
				term = (64'd1 << (62 - s)) / 64'(2 * k + 1);
				if (k % 2 == 1) rad = rad - term;
				else rad = rad + term;
			end
		end
		return ((rad >> 30) * 64'd3845054675) >> 26;
	endfunction

	function automatic logic [63:0] atan_step(input int i, input int frac);
		logic [63:0] q;
		int sh;
		q = atan_deg_q32(i);
		sh = 32 - frac;
		return (q + (64'd1 << (sh - 1))) >> sh;
	endfunction
endpackage

FILE: src/icf_datapath.sv
module icf_datapath import icf_pkg::*; #(
	parameter int CORDIC_STEPS    = CordicStepsDefault,
	parameter int ANGLE_FRAC_BITS = AngleFracDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  icf_cmd_t           cmd,
	output icf_sts_t           sts,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic [16:0]        blend_weight,
	input  logic [15:0]        gyro_gain,
	input  logic [16:0]        magnitude_low,
	input  logic [16:0]        magnitude_high,
	output logic signed [31:0] pitch_out,
	output logic signed [31:0] roll_out,
	output logic               corrected
);
	localparam logic signed [63:0] Deg180 = 64'sd180 <<< ANGLE_FRAC_BITS;

	logic signed [31:0] pitch_q, roll_q;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic               corr_q;
	logic signed [63:0] cx_q, cy_q, cz_q;
	logic [StepW-1:0]   step_q;
	logic signed [49:0] prod_a_q, prod_b_q;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [16:0] abs16(input logic signed [15:0] v);
		return v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
	endfunction

	logic [63:0] atan_tab [CORDIC_STEPS];
	always_comb begin
		for (int i = 0; i < CORDIC_STEPS; i++) atan_tab[i] = atan_step(i, ANGLE_FRAC_BITS);
	end

	logic signed [32:0] gx_p, gy_p;
	logic [18:0]        mag;
	assign gx_p = gyro_x * $signed({1'b0, gyro_gain});
	assign gy_p = gyro_y * $signed({1'b0, gyro_gain});
	assign mag  = 19'(abs16(accel_x)) + 19'(abs16(accel_y)) + 19'(abs16(accel_z));

	logic signed [15:0] cy_in;
	logic signed [63:0] x0, y0;
	assign cy_in = cmd.sel ? ax_q : ay_q;
	assign x0    = 64'(az_q) <<< 16;
	assign y0    = 64'(cy_in) <<< 16;

	logic signed [63:0] dx, dy;
	assign dx = cy_q >>> step_q;
	assign dy = cx_q >>> step_q;

	logic [16:0]        alpha;
	logic signed [31:0] acc_ang, cur_ang;
	assign alpha   = (blend_weight > 17'd65536) ? 17'd65536 : blend_weight;
	assign acc_ang = sat32(66'(cz_q));
	assign cur_ang = cmd.sel ? roll_q : pitch_q;

	logic signed [31:0] blended;
	assign blended = sat32(66'((51'(prod_a_q) + 51'(prod_b_q)) >>> 16));

	assign sts.corr     = corr_q;
	assign sts.cor_last = (32'(step_q) == CORDIC_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= '0;
			roll_q  <= '0;
			corr_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				pitch_q <= sat32(66'(pitch_q) + 66'(gx_p));
				roll_q  <= sat32(66'(roll_q) - 66'(gy_p));
				corr_q  <= (mag > 19'(magnitude_low)) && (mag < 19'(magnitude_high));
			end
			if (cmd.blend_wr) begin
				if (cmd.sel) roll_q <= blended;
				else pitch_q <= blended;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
		end
		if (cmd.cor_init) begin
			step_q <= '0;
			if (x0 < 0) begin
				cx_q <= -x0;
				cy_q <= -y0;
				cz_q <= (y0 >= 0) ? Deg180 : -Deg180;
			end else begin
				cx_q <= x0;
				cy_q <= y0;
				cz_q <= '0;
			end
		end else if (cmd.cor_step) begin
			step_q <= step_q + 1'b1;
			if (cy_q > 0) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + $signed(atan_tab[step_q]);
			end else if (cy_q < 0) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - $signed(atan_tab[step_q]);
			end
		end
		if (cmd.blend_mul) begin
			prod_a_q <= 50'($signed({1'b0, 17'd65536 - alpha})) * 50'(cur_ang);
			prod_b_q <= 50'($signed({1'b0, alpha})) * 50'(acc_ang);
		end
		if (cmd.out_load) begin
			pitch_out <= pitch_q;
			roll_out  <= roll_q;
			corrected <= corr_q;
		end
	end
endmodule

FILE: src/icf_ctrl.sv
`include "imu_complementary_filter_top_macros.svh"
module icf_ctrl import icf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  icf_sts_t sts,
	output icf_cmd_t cmd
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_INIT  = 6'b000010,
		S_ITER  = 6'b000100,
		S_MUL   = 6'b001000,
		S_WR    = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	logic   sel_q;
	logic   out_valid_q;
	logic   take;

	assign in_stall  = (state_q != S_IDLE);
	assign take      = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.sel      = sel_q;
		cmd.load     = take;
		cmd.cor_init = (state_q == S_INIT);
		cmd.cor_step = (state_q == S_ITER);
		cmd.blend_mul = (state_q == S_MUL);
		cmd.blend_wr = (state_q == S_WR);
		cmd.out_load = (state_q == S_OUT) && !(out_valid_q && out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (take) state_q <= S_INIT;
				S_INIT: begin
					if (sts.corr) state_q <= S_ITER;
					else state_q <= S_OUT;
				end
				S_ITER: if (sts.cor_last) state_q <= S_MUL;
				S_MUL:  state_q <= S_WR;
				S_WR: begin
					sel_q <= !sel_q;
					state_q <= sel_q ? S_OUT : S_INIT;
				end
				S_OUT: if (cmd.out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ICF_ASSERT_NOW(a_busy_stall, clk, arst_n, state_q != S_IDLE, in_stall, "accepting while busy")
	`ICF_ASSERT_NEXT(a_take_init, clk, arst_n, take, state_q == S_INIT, "missed start")
	`ICF_ASSERT_NEXT(a_out_set, clk, arst_n, cmd.out_load, out_valid, "result not shown")
	`ICF_ASSERT_NOW(a_sel_idle, clk, arst_n, state_q == S_IDLE, !sel_q, "roll pass left open")
endmodule

FILE: src/imu_complementary_filter_top.sv
// Pitch/roll complementary filter. One sample is taken per transfer; in_stall stays high
// while it is processed. With accelerometer correction it runs two CORDIC atan2 passes
// of CORDIC_STEPS iterations each on one shared shift-add unit, plus init, multiply and
// write-back; without correction it goes from init straight to the output stage. The result
// waits in an output register until taken.
module imu_complementary_filter_top import icf_pkg::*; #(
	parameter int CORDIC_STEPS    = CordicStepsDefault,
	parameter int ANGLE_FRAC_BITS = AngleFracDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pitch_out,
	output logic signed [31:0] roll_out,
	output logic               corrected,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data
);
	logic [16:0] blend_q, mlow_q, mhigh_q;
	logic [15:0] gain_q;
	icf_cmd_t    cmd;
	icf_sts_t    sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q <= 17'd6554;
			gain_q  <= 16'd10;
			mlow_q  <= 17'd8192;
			mhigh_q <= 17'd32768;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLEND: blend_q <= cfg_data;
				REG_GAIN:  gain_q  <= cfg_data[15:0];
				REG_MLOW:  mlow_q  <= cfg_data;
				REG_MHIGH: mhigh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	icf_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	icf_datapath #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.accel_x, .accel_y, .accel_z, .gyro_x, .gyro_y,
		.blend_weight(blend_q), .gyro_gain(gain_q),
		.magnitude_low(mlow_q), .magnitude_high(mhigh_q),
		.pitch_out, .roll_out, .corrected
	);
endmodule
